### hw/rtl/cqr_pkg.sv
// ----------------------------------------------------------------------------
// cqr_pkg
// Shared types and constants of the circular queue with reverse.
// ----------------------------------------------------------------------------
package cqr_pkg;

  localparam int DEPTH   = 16;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int CAP_W   = 5;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [KIND_W-1:0] KIND_ENQ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REV = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDA,
    ST_RDB,
    ST_WRA,
    ST_WRB,
    ST_RD,
    ST_OUT
  } state_t;

endpackage

### hw/rtl/circular_queue_with_reverse.sv
// ----------------------------------------------------------------------------
// circular_queue_with_reverse
// Ring-buffer queue of signed words with capacity register and reverse.
// ----------------------------------------------------------------------------
// Each request (enqueue, dequeue or reverse) is taken when start is high and
// busy is low, and answers with one result on done, in state ST_OUT after
// ST_RD; the next request can be taken in the cycle after done. A reverse
// of n entries first does floor(n/2) swaps in ST_RDA, ST_RDB, ST_WRA and
// ST_WRB, each taking two reads and two writes on the single read port and
// single write port of the ring memory, whose read is registered.
// Results are held for one cycle only. A capacity write empties the queue
// and is taken only while busy and start are low.
module circular_queue_with_reverse (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [cqr_pkg::KIND_W-1:0]        kind,
  input  logic signed [cqr_pkg::WORD_W-1:0] value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cqr_pkg::CAP_W-1:0]         cfg_data,
  output logic                              done,
  output logic signed [cqr_pkg::WORD_W-1:0] front_value,
  output logic                              is_empty,
  output logic                              is_full,
  output logic [cqr_pkg::STAT_W-1:0]        status,
  output logic [cqr_pkg::COUNT_W-1:0]       count
);

  localparam int AW = cqr_pkg::AW;
  localparam int CW = cqr_pkg::CW;

  cqr_pkg::state_t state, state_next;

  logic [cqr_pkg::CAP_W-1:0]  capacity;
  logic [AW-1:0]              head, head_next;
  logic [CW-1:0]              cnt, cnt_next;
  logic [CW-1:0]              idx, idx_next;
  logic [cqr_pkg::STAT_W-1:0] stat, stat_next;
  logic [cqr_pkg::WORD_W-1:0] tmp_a, tmp_a_next;

  logic [CW-1:0]              cap;
  logic [CW-1:0]              pairs;
  logic [AW-1:0]              lo_slot, hi_slot;

  logic                       we;
  logic [AW-1:0]              waddr, raddr;
  logic [cqr_pkg::WORD_W-1:0] wdata, rdata;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h,
                                         input logic [CW-1:0] off,
                                         input logic [CW-1:0] c);
    logic [CW:0] s;
    logic [CW:0] w;
    s = {1'b0, CW'(h)} + {1'b0, off};
    w = (s >= {1'b0, c}) ? (s - {1'b0, c}) : s;
    return AW'(w);
  endfunction

  // effective capacity, clamped to 1..DEPTH
  always_comb begin
    if (capacity == '0) begin
      cap = CW'(1);
    end else if (32'(capacity) > 32'(cqr_pkg::DEPTH)) begin
      cap = CW'(cqr_pkg::DEPTH);
    end else begin
      cap = CW'(capacity);
    end
  end

  assign pairs   = cnt >> 1;
  assign lo_slot = slot(head, idx, cap);
  assign hi_slot = slot(head, cnt - CW'(1) - idx, cap);

  assign busy      = (state != cqr_pkg::ST_IDLE);
  assign cfg_ready = (state == cqr_pkg::ST_IDLE) && !start;

  always_comb begin
    state_next = state;
    head_next  = head;
    cnt_next   = cnt;
    idx_next   = idx;
    stat_next  = stat;
    tmp_a_next = tmp_a;
    we         = 1'b0;
    waddr      = lo_slot;
    wdata      = rdata;
    raddr      = head;
    case (state)
      cqr_pkg::ST_IDLE: begin
        if (start) begin
          stat_next  = cqr_pkg::STAT_DONE;
          idx_next   = '0;
          state_next = cqr_pkg::ST_RD;
          case (kind)
            cqr_pkg::KIND_ENQ: begin
              if (cnt >= cap) begin
                stat_next = cqr_pkg::STAT_FULL;
              end else begin
                we       = 1'b1;
                waddr    = slot(head, cnt, cap);
                wdata    = value;
                cnt_next = cnt + CW'(1);
              end
            end
            cqr_pkg::KIND_DEQ: begin
              if (cnt == '0) begin
                stat_next = cqr_pkg::STAT_EMPTY;
              end else begin
                head_next = slot(head, CW'(1), cap);
                cnt_next  = cnt - CW'(1);
              end
            end
            cqr_pkg::KIND_REV: begin
              if (cnt >= CW'(2)) begin
                state_next = cqr_pkg::ST_RDA;
              end
            end
            default: begin
            end
          endcase
        end
      end
      cqr_pkg::ST_RDA: begin
        raddr      = lo_slot;
        state_next = cqr_pkg::ST_RDB;
      end
      cqr_pkg::ST_RDB: begin
        raddr      = hi_slot;
        tmp_a_next = rdata;
        state_next = cqr_pkg::ST_WRA;
      end
      cqr_pkg::ST_WRA: begin
        we         = 1'b1;
        waddr      = lo_slot;
        wdata      = rdata;
        state_next = cqr_pkg::ST_WRB;
      end
      cqr_pkg::ST_WRB: begin
        we       = 1'b1;
        waddr    = hi_slot;
        wdata    = tmp_a;
        idx_next = idx + CW'(1);
        if (idx + CW'(1) < pairs) begin
          state_next = cqr_pkg::ST_RDA;
        end else begin
          state_next = cqr_pkg::ST_RD;
        end
      end
      cqr_pkg::ST_RD: begin
        raddr      = head;
        state_next = cqr_pkg::ST_OUT;
      end
      cqr_pkg::ST_OUT: begin
        state_next = cqr_pkg::ST_IDLE;
      end
      default: begin
        state_next = cqr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cqr_pkg::ST_IDLE;
      capacity <= cqr_pkg::CAP_RESET;
      head     <= '0;
      cnt      <= '0;
      idx      <= '0;
      stat     <= cqr_pkg::STAT_DONE;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      stat  <= stat_next;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
        head     <= '0;
        cnt      <= '0;
      end else begin
        head <= head_next;
        cnt  <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    tmp_a <= tmp_a_next;
  end

  cqr_ram #(
    .WIDTH (cqr_pkg::WORD_W),
    .DEPTH (cqr_pkg::DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign done        = (state == cqr_pkg::ST_OUT);
  assign is_empty    = (cnt == '0);
  assign is_full     = (cnt >= cap);
  assign status      = stat;
  assign count       = cqr_pkg::COUNT_W'(cnt);
  assign front_value = is_empty ? -32'sd1 : signed'(rdata);

`ifndef NO_ASSERTIONS
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= cap)
    else $error("entry count above capacity");

  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, CW'(head)} < {1'b0, cap})
    else $error("head outside ring");

  a_take_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken without going busy");

  a_empty_front: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (front_value == -32'sd1))
    else $error("empty queue reports a front word");

  a_refused_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (done && (status != cqr_pkg::STAT_DONE)) |-> $stable(cnt))
    else $error("refused request changed the count");
`endif

endmodule

### hw/rtl/cqr_ram.sv
// ----------------------------------------------------------------------------
// cqr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cqr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### test/circular_queue_with_reverse_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_queue_with_reverse_tb
// Self-checking bench for the ring-buffer queue with capacity register and
// reverse. A short directed table covers the empty and full refusals, the
// extreme words, the unknown command, short reverses and the capacity edge
// values. Random phases at various capacities then drive bursts that lean
// towards filling or draining the queue. Each result is checked against a
// fixed reply or an in-bench model of the ring, head and count.
// ----------------------------------------------------------------------------
module circular_queue_with_reverse_tb;

  localparam logic [cqr_pkg::KIND_W-1:0] KIND_NOP = 2'd3;
  localparam int WATCHDOG    = 2000;
  localparam int SETTLE      = 40;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 112;

  typedef struct packed {
    logic [cqr_pkg::WORD_W-1:0]  front;
    logic                        empty;
    logic                        full;
    logic [cqr_pkg::STAT_W-1:0]  stat;
    logic [cqr_pkg::COUNT_W-1:0] cnt;
  } reply_t;

  typedef struct {
    bit                         is_cfg;
    logic [cqr_pkg::KIND_W-1:0] kind;
    logic [cqr_pkg::WORD_W-1:0] word;
    bit                         typed;
    reply_t                     want;
  } step_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic                              busy;
  logic [cqr_pkg::KIND_W-1:0]        kind = '0;
  logic signed [cqr_pkg::WORD_W-1:0] value = '0;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [cqr_pkg::CAP_W-1:0]         cfg_data = '0;
  logic                              done;
  logic signed [cqr_pkg::WORD_W-1:0] front_value;
  logic                              is_empty;
  logic                              is_full;
  logic [cqr_pkg::STAT_W-1:0]        status;
  logic [cqr_pkg::COUNT_W-1:0]       count;

  // model of the queue
  logic [cqr_pkg::WORD_W-1:0] slots [cqr_pkg::DEPTH];
  int unsigned                head_at = 0;
  int unsigned                held = 0;
  logic [cqr_pkg::CAP_W-1:0]  cap_reg = cqr_pkg::CAP_RESET;

  reply_t replies_due [$];
  int     faults = 0;
  int     quiet_cycles = 0;
  int     idle_pct = 0;

  logic [cqr_pkg::CAP_W-1:0] phase_cap [PHASES] = '{5'd16, 5'd1, 5'd0, 5'd5, 5'd31,
                                                    5'd2, 5'd17, 5'd3, 5'd8, 5'd16,
                                                    5'd4, 5'd15};
  int                        gap_pct [3] = '{0, 45, 32};

  circular_queue_with_reverse DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .value      (value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .done       (done),
    .front_value(front_value),
    .is_empty   (is_empty),
    .is_full    (is_full),
    .status     (status),
    .count      (count)
  );

  always #4 clk = ~clk;

  function automatic reply_t reply(input logic [cqr_pkg::WORD_W-1:0] f,
                                   input logic e, input logic u,
                                   input logic [cqr_pkg::STAT_W-1:0] s,
                                   input logic [cqr_pkg::COUNT_W-1:0] c);
    reply_t r;
    r.front = f;
    r.empty = e;
    r.full  = u;
    r.stat  = s;
    r.cnt   = c;
    return r;
  endfunction

  function automatic step_t cmd_step(input logic [cqr_pkg::KIND_W-1:0] k,
                                     input logic [cqr_pkg::WORD_W-1:0] w);
    step_t s;
    s.is_cfg = 1'b0;
    s.kind   = k;
    s.word   = w;
    s.typed  = 1'b0;
    s.want   = '0;
    return s;
  endfunction

  function automatic step_t chk_step(input logic [cqr_pkg::KIND_W-1:0] k,
                                     input logic [cqr_pkg::WORD_W-1:0] w,
                                     input reply_t r);
    step_t s;
    s       = cmd_step(k, w);
    s.typed = 1'b1;
    s.want  = r;
    return s;
  endfunction

  function automatic step_t cfg_step(input logic [cqr_pkg::CAP_W-1:0] c);
    step_t s;
    s        = cmd_step(cqr_pkg::KIND_ENQ, {{(cqr_pkg::WORD_W-cqr_pkg::CAP_W){1'b0}}, c});
    s.is_cfg = 1'b1;
    return s;
  endfunction

  function automatic reply_t run_command(input logic [cqr_pkg::KIND_W-1:0] k,
                                         input logic [cqr_pkg::WORD_W-1:0] w);
    int unsigned                cap;
    int unsigned                a;
    int unsigned                b;
    logic [cqr_pkg::WORD_W-1:0] t;
    reply_t                     r;
    if (cap_reg == '0)
      cap = 1;
    else if (32'(cap_reg) > 32'(cqr_pkg::DEPTH))
      cap = cqr_pkg::DEPTH;
    else
      cap = 32'(cap_reg);
    r      = '0;
    r.stat = cqr_pkg::STAT_DONE;
    case (k)
      cqr_pkg::KIND_ENQ: begin
        if (held >= cap) begin
          r.stat = cqr_pkg::STAT_FULL;
        end else begin
          a = (head_at + held) % cap;
          slots[a[cqr_pkg::AW-1:0]] = w;
          held++;
        end
      end
      cqr_pkg::KIND_DEQ: begin
        if (held == 0) begin
          r.stat = cqr_pkg::STAT_EMPTY;
        end else begin
          head_at = (head_at + 1) % cap;
          held--;
        end
      end
      cqr_pkg::KIND_REV: begin
        for (int unsigned i = 0; i < held / 2; i++) begin
          a = (head_at + i) % cap;
          b = (head_at + held - 1 - i) % cap;
          t = slots[a[cqr_pkg::AW-1:0]];
          slots[a[cqr_pkg::AW-1:0]] = slots[b[cqr_pkg::AW-1:0]];
          slots[b[cqr_pkg::AW-1:0]] = t;
        end
      end
      default: begin
      end
    endcase
    a       = head_at % cap;
    r.front = (held == 0) ? '1 : slots[a[cqr_pkg::AW-1:0]];
    r.empty = (held == 0);
    r.full  = (held >= cap);
    r.cnt   = held[cqr_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic issue(input logic [cqr_pkg::KIND_W-1:0] k,
                       input logic [cqr_pkg::WORD_W-1:0] w,
                       input bit typed, input reply_t fixed);
    reply_t calc;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind  <= k;
    value <= w;
    do @(posedge clk); while (busy);
    calc = run_command(k, w);
    replies_due.push_back(typed ? fixed : calc);
  endtask

  task automatic set_capacity(input logic [cqr_pkg::CAP_W-1:0] c);
    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_reg = c;
    head_at = 0;
    held    = 0;
  endtask

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst) begin
      if ((start && !busy) || done || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("circular_queue_with_reverse_tb NOT OK");
        $finish;
      end
      if (done) begin
        got = reply(front_value, is_empty, is_full, status, count);
        if (replies_due.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("result with no request pending: %s %h %s %b %s %b %s %0d %s %0d",
                     "front", got.front, "empty", got.empty, "full", got.full,
                     "status", got.stat, "count", got.cnt);
        end else begin
          want = replies_due.pop_front();
          if (got.front !== want.front || got.empty !== want.empty ||
              got.full !== want.full || got.stat !== want.stat ||
              got.cnt !== want.cnt) begin
            faults++;
            if (faults <= 10) begin
              $display("mismatch: want front %h empty %b full %b status %0d count %0d,",
                       want.front, want.empty, want.full, want.stat, want.cnt);
              $display("          got  front %h empty %b full %b status %0d count %0d",
                       got.front, got.empty, got.full, got.stat, got.cnt);
            end
          end
        end
      end
    end
  end

  initial begin
    step_t                      plan [$];
    logic [cqr_pkg::KIND_W-1:0] k;
    logic [cqr_pkg::WORD_W-1:0] w;
    int                         lean_left;
    bit                         enq_lean;
    int                         pick;

    enq_lean = 1'b0;
    // starts at reset capacity
    plan.push_back(chk_step(cqr_pkg::KIND_DEQ, 32'h0,
                            reply('1, 1'b1, 1'b0, cqr_pkg::STAT_EMPTY, 5'd0)));
    plan.push_back(chk_step(cqr_pkg::KIND_REV, 32'h0,
                            reply('1, 1'b1, 1'b0, cqr_pkg::STAT_DONE, 5'd0)));
    plan.push_back(chk_step(KIND_NOP, 32'hFFFF_FFFF,
                            reply('1, 1'b1, 1'b0, cqr_pkg::STAT_DONE, 5'd0)));
    plan.push_back(chk_step(cqr_pkg::KIND_ENQ, 32'h7FFF_FFFF,
                            reply(32'h7FFF_FFFF, 1'b0, 1'b0, cqr_pkg::STAT_DONE, 5'd1)));
    plan.push_back(chk_step(cqr_pkg::KIND_REV, 32'h0,
                            reply(32'h7FFF_FFFF, 1'b0, 1'b0, cqr_pkg::STAT_DONE, 5'd1)));
    plan.push_back(chk_step(cqr_pkg::KIND_ENQ, 32'h8000_0000,
                            reply(32'h7FFF_FFFF, 1'b0, 1'b0, cqr_pkg::STAT_DONE, 5'd2)));
    plan.push_back(chk_step(cqr_pkg::KIND_REV, 32'h0,
                            reply(32'h8000_0000, 1'b0, 1'b0, cqr_pkg::STAT_DONE, 5'd2)));
    plan.push_back(cmd_step(cqr_pkg::KIND_ENQ, 32'hFFFF_FFFF));
    plan.push_back(cmd_step(cqr_pkg::KIND_ENQ, 32'h0000_0000));
    plan.push_back(cmd_step(cqr_pkg::KIND_ENQ, 32'h1234_5678));
    plan.push_back(cmd_step(cqr_pkg::KIND_REV, 32'h0));
    plan.push_back(cmd_step(cqr_pkg::KIND_DEQ, 32'h0));
    // zero capacity behaves as one
    plan.push_back(cfg_step(5'd0));
    plan.push_back(chk_step(cqr_pkg::KIND_ENQ, 32'h5555_5555,
                            reply(32'h5555_5555, 1'b0, 1'b1, cqr_pkg::STAT_DONE, 5'd1)));
    plan.push_back(chk_step(cqr_pkg::KIND_ENQ, 32'hAAAA_AAAA,
                            reply(32'h5555_5555, 1'b0, 1'b1, cqr_pkg::STAT_FULL, 5'd1)));
    plan.push_back(chk_step(cqr_pkg::KIND_DEQ, 32'h0,
                            reply('1, 1'b1, 1'b0, cqr_pkg::STAT_DONE, 5'd0)));
    // wrap round a small ring
    plan.push_back(cfg_step(5'd3));
    plan.push_back(cmd_step(cqr_pkg::KIND_ENQ, 32'd1));
    plan.push_back(cmd_step(cqr_pkg::KIND_ENQ, 32'd2));
    plan.push_back(cmd_step(cqr_pkg::KIND_ENQ, 32'd3));
    plan.push_back(chk_step(cqr_pkg::KIND_ENQ, 32'd4,
                            reply(32'd1, 1'b0, 1'b1, cqr_pkg::STAT_FULL, 5'd3)));
    plan.push_back(cmd_step(cqr_pkg::KIND_DEQ, 32'h0));
    plan.push_back(cmd_step(cqr_pkg::KIND_ENQ, 32'd5));
    plan.push_back(cmd_step(cqr_pkg::KIND_REV, 32'h0));
    plan.push_back(cmd_step(cqr_pkg::KIND_DEQ, 32'h0));
    // capacity above the store depth
    plan.push_back(cfg_step(5'd31));
    plan.push_back(chk_step(cqr_pkg::KIND_ENQ, 32'hFFFF_FFFB,
                            reply(32'hFFFF_FFFB, 1'b0, 1'b0, cqr_pkg::STAT_DONE, 5'd1)));
    plan.push_back(chk_step(KIND_NOP, 32'h0,
                            reply(32'hFFFF_FFFB, 1'b0, 1'b0, cqr_pkg::STAT_DONE, 5'd1)));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[n]) begin
      if (plan[n].is_cfg)
        set_capacity(plan[n].word[cqr_pkg::CAP_W-1:0]);
      else
        issue(plan[n].kind, plan[n].word, plan[n].typed, plan[n].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      set_capacity(phase_cap[p]);
      idle_pct  = gap_pct[p % 3];
      lean_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // bursts that lean towards filling or draining
        if (lean_left == 0) begin
          enq_lean  = ~enq_lean;
          lean_left = $urandom_range(40, 10);
        end
        lean_left--;
        pick = $urandom_range(99);
        if (pick < 3)
          k = KIND_NOP;
        else if (pick < 18)
          k = cqr_pkg::KIND_REV;
        else if (pick < (enq_lean ? 88 : 38))
          k = cqr_pkg::KIND_ENQ;
        else
          k = cqr_pkg::KIND_DEQ;
        w = $urandom();
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(3))
            0: w = 32'h8000_0000;
            1: w = 32'h7FFF_FFFF;
            2: w = 32'hFFFF_FFFF;
            default: w = 32'h0;
          endcase
        end
        issue(k, w, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (faults == 0)
      $display("circular_queue_with_reverse_tb OK");
    else
      $display("circular_queue_with_reverse_tb NOT OK");
    $finish;
  end

endmodule
